// File: rtl/core/fcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcw_pkg
// Shared types and constants of the FAT16 cluster chain walker.
// ----------------------------------------------------------------------------
package fcw_pkg;

    localparam int DEF_TABLE_ENTRIES = 4096;
    localparam int DEF_MAX_CHAIN     = 64;

    localparam int CL_W  = 16;
    localparam int IDX_W = 12;
    localparam int ERR_W = 2;

    localparam logic [CL_W-1:0] END_MARK      = 16'hFFF8;
    localparam logic [CL_W-1:0] FIRST_CLUSTER = 16'h0001;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_WALK = 1'b1;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TOO_LONG = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OUTSIDE  = 2'd2;

    typedef struct packed {
        logic            en;
        logic [CL_W-1:0] cluster;
    } mem_rd_t;

    typedef struct packed {
        logic            en;
        logic [CL_W-1:0] cluster;
        logic [CL_W-1:0] link;
    } mem_wr_t;

endpackage
`default_nettype wire

// File: rtl/core/fcw_link_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcw_link_mem
// Link table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fcw_link_mem #(
    parameter int TABLE_ENTRIES = fcw_pkg::DEF_TABLE_ENTRIES
) (
    input  wire logic                  clk,
    input  wire fcw_pkg::mem_wr_t      wr,
    input  wire fcw_pkg::mem_rd_t      rd,
    output logic [fcw_pkg::CL_W-1:0]   rd_data
);
    import fcw_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [CL_W-1:0] mem [TABLE_ENTRIES];
    logic [CL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.cluster[AW-1:0]] <= wr.link;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.cluster[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: rtl/core/fcw_walk_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcw_walk_engine
// Chain walk sequencer: issues table reads, classifies links, holds results.
// ----------------------------------------------------------------------------
module fcw_walk_engine #(
    parameter int TABLE_ENTRIES = fcw_pkg::DEF_TABLE_ENTRIES,
    parameter int MAX_CHAIN     = fcw_pkg::DEF_MAX_CHAIN
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [fcw_pkg::CL_W-1:0] start_cluster,
    output logic                        busy,
    output fcw_pkg::mem_rd_t            rd,
    input  wire logic [fcw_pkg::CL_W-1:0] rd_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [fcw_pkg::CL_W-1:0]    cluster_number,
    output logic                        last_in_chain,
    output logic [fcw_pkg::ERR_W-1:0]   walk_error
);
    import fcw_pkg::*;

    localparam int CNT_W = $clog2(MAX_CHAIN);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CL_W-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CL_W-1:0]  res_cl_reg, res_cl_next;
    logic             res_last_reg, res_last_next;
    logic [ERR_W-1:0] res_err_reg, res_err_next;

    logic [CL_W-1:0]  probe;
    logic [CL_W-1:0]  link;
    logic             probe_end;
    logic             probe_out;

    always_comb
    begin
        probe     = (state_reg == ST_IDLE) ? start_cluster : cur_reg;
        if (probe == '0)
        begin
            probe = FIRST_CLUSTER;
        end
        probe_end = (probe >= END_MARK);
        probe_out = ({1'b0, probe} >= (CL_W+1)'(TABLE_ENTRIES));
        link      = (rd_data == '0) ? FIRST_CLUSTER : rd_data;
    end

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        res_cl_next   = res_cl_reg;
        res_last_next = res_last_reg;
        res_err_next  = res_err_reg;
        rd.en         = 1'b0;
        rd.cluster    = probe;

        unique case (state_reg)
            ST_IDLE, ST_EMIT:
            begin
                if ((state_reg == ST_IDLE && start) ||
                    (state_reg == ST_EMIT && !out_stall && !res_last_reg))
                begin
                    cur_next = probe;
                    if (state_reg == ST_IDLE)
                    begin
                        cnt_next = '0;
                    end
                    if (probe_end)
                    begin
                        res_cl_next   = probe;
                        res_last_next = 1'b1;
                        res_err_next  = ERR_NONE;
                        state_next    = ST_EMIT;
                    end
                    else if (probe_out)
                    begin
                        res_cl_next   = probe;
                        res_last_next = 1'b1;
                        res_err_next  = ERR_OUTSIDE;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        rd.en      = 1'b1;
                        state_next = ST_READ;
                    end
                end
                else if (state_reg == ST_EMIT && !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                res_cl_next = cur_reg;
                state_next  = ST_EMIT;
                if (link >= END_MARK)
                begin
                    res_last_next = 1'b1;
                    res_err_next  = ERR_NONE;
                end
                else if (cnt_reg == CNT_W'(MAX_CHAIN - 1))
                begin
                    res_last_next = 1'b1;
                    res_err_next  = ERR_TOO_LONG;
                end
                else
                begin
                    res_last_next = 1'b0;
                    res_err_next  = ERR_NONE;
                    cur_next      = link;
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        cnt_reg      <= cnt_next;
        res_cl_reg   <= res_cl_next;
        res_last_reg <= res_last_next;
        res_err_reg  <= res_err_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign out_valid      = (state_reg == ST_EMIT);
    assign cluster_number = res_cl_reg;
    assign last_in_chain  = res_last_reg;
    assign walk_error     = res_err_reg;

endmodule
`default_nettype wire

// File: rtl/core/fat16_cluster_chain_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fat16_cluster_chain_walker
// FAT16 allocation table held in on-chip memory, with a chain walker.
//
// Input channel (in_valid / in_stall): a load item (req_type 0) writes
// entry_value at entry_index and gives no result; an index at or beyond
// TABLE_ENTRIES is dropped. A walk item (req_type 1) emits the
// chain from start_cluster, one output transfer per cluster, last one
// flagged, with walk_error set when the chain is cut by MAX_CHAIN or by a
// link outside the table.
// A walk reads the table once per cluster and then holds the result in the
// emit state; with no output stall the next read is issued from the emit
// state. A cluster at or above the end mark or outside the table needs no
// read and goes straight to the emit state. The single read port of the
// table sets the pace of a walk.
// in_stall stays high from a walk's acceptance until its last result has
// been transferred. An output stall holds the result register and the walk.
// Reset clears the sequencer state register only; table entries are undefined until loaded.
// ----------------------------------------------------------------------------
module fat16_cluster_chain_walker #(
    parameter int TABLE_ENTRIES = fcw_pkg::DEF_TABLE_ENTRIES,
    parameter int MAX_CHAIN     = fcw_pkg::DEF_MAX_CHAIN
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      req_type,
    input  wire logic [fcw_pkg::IDX_W-1:0] entry_index,
    input  wire logic [fcw_pkg::CL_W-1:0]  entry_value,
    input  wire logic [fcw_pkg::CL_W-1:0]  start_cluster,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [fcw_pkg::CL_W-1:0]       cluster_number,
    output logic                           last_in_chain,
    output logic [fcw_pkg::ERR_W-1:0]      walk_error
);
    import fcw_pkg::*;

    logic            busy;
    logic            in_xfer;
    logic            walk_start;
    mem_wr_t         wr;
    mem_rd_t         rd;
    logic [CL_W-1:0] rd_data;

    assign in_stall   = busy;
    assign in_xfer    = in_valid && !in_stall;
    assign walk_start = in_xfer && (req_type == REQ_WALK);

    always_comb
    begin
        wr.en      = in_xfer && (req_type == REQ_LOAD) &&
                     ((CL_W+1)'(entry_index) < (CL_W+1)'(TABLE_ENTRIES));
        wr.cluster = CL_W'(entry_index);
        wr.link    = entry_value;
    end

    fcw_link_mem #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_mem (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    fcw_walk_engine #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .MAX_CHAIN    (MAX_CHAIN)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (walk_start),
        .start_cluster  (start_cluster),
        .busy           (busy),
        .rd             (rd),
        .rd_data        (rd_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cluster_number (cluster_number),
        .last_in_chain  (last_in_chain),
        .walk_error     (walk_error)
    );

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (walk_error != ERR_NONE) |-> last_in_chain)
        else $error("error code on a result that is not last");

    a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");

    a_end_mark_start: assert property (@(posedge clk) disable iff (!rst_n)
        walk_start && (start_cluster >= END_MARK) |=>
            out_valid && last_in_chain && (walk_error == ERR_NONE) &&
            (cluster_number == $past(start_cluster)))
        else $error("end-mark start not emitted alone");

    a_outside_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (walk_error == ERR_OUTSIDE) |->
            ({1'b0, cluster_number} >= (CL_W+1)'(TABLE_ENTRIES)))
        else $error("outside-table error on a cluster inside the table");

endmodule
`default_nettype wire
